@@ design/fir_pkg.sv @@
// fir_pkg: shared constants, operation codes and controller command type
// for the streaming fir filter; no dependencies
package fir_pkg;

   localparam int TAPS_MAX       = 64;
   localparam int SAMPLE_BITS    = 16;
   localparam int ACC_BITS       = 40;
   localparam int IDX_BITS       = $clog2(TAPS_MAX);
   localparam int TAP_COUNT_BITS = 7;
   localparam int COEFF_IDX_BITS = 6;
   localparam int OP_BITS        = 2;

   localparam logic [TAP_COUNT_BITS-1:0] TAP_RESET = TAP_COUNT_BITS'(64);

   localparam logic [OP_BITS-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_BITS-1:0] OP_COEFF  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FLUSH  = 2'd2;

   localparam logic REG_TAP_COUNT = 1'b0;

   typedef struct packed {
      logic                sample_wr;
      logic                coeff_wr;
      logic                flush;
      logic                issue;
      logic [IDX_BITS-1:0] tap_idx;
      logic                load_result;
   } fir_cmd_type;

endpackage

@@ design/fir_ctrl.sv @@
// fir_ctrl: request decode and tap sequencer for the fir filter
// depends on fir_pkg
module fir_ctrl
   import fir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [OP_BITS-1:0]        req_operation,
   input  logic [TAP_COUNT_BITS-1:0] tap_count,
   input  logic                      rsp_free,
   output logic                      req_ready,
   output fir_cmd_type               cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [IDX_BITS-1:0]       tap_ff, tap_in;
   logic [IDX_BITS-1:0]       last_ff, last_in;
   logic                      drain_ff, drain_in;
   logic [TAP_COUNT_BITS-1:0] taps_clip;

   // zero acts as one, oversized counts clip to the store depth
   always_comb begin
      if (tap_count == '0) begin
         taps_clip = TAP_COUNT_BITS'(1);
      end else if (32'(tap_count) > TAPS_MAX) begin
         taps_clip = TAP_COUNT_BITS'(TAPS_MAX);
      end else begin
         taps_clip = tap_count;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      last_in   = last_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.tap_idx = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_operation)
                  OP_FILTER: begin
                     cmd.sample_wr = 1'b1;
                     tap_in        = '0;
                     last_in       = IDX_BITS'(taps_clip - TAP_COUNT_BITS'(1));
                     state_in      = ST_MAC;
                  end
                  OP_COEFF: cmd.coeff_wr = 1'b1;
                  OP_FLUSH: cmd.flush    = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (tap_ff == last_ff) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the read and multiply stages to empty
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         last_ff  <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         last_ff  <= last_in;
         drain_ff <= drain_in;
      end
   end

endmodule

@@ design/fir_datapath.sv @@
// fir_datapath: history and coefficient memories, multiply-accumulate
// pipeline, rounding and saturation; depends on fir_pkg
module fir_datapath
   import fir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  fir_cmd_type                   cmd,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   input  logic [COEFF_IDX_BITS-1:0]     req_coeff_index,
   input  logic [SAMPLE_BITS-1:0]        req_coeff_value,
   output logic [SAMPLE_BITS-1:0]        filtered,
   output logic                          saturated
);

   localparam logic signed [ACC_BITS:0] RND_HALF = (ACC_BITS+1)'(2**(SAMPLE_BITS-2));
   localparam logic signed [ACC_BITS:0] OUT_MAX =
      {{(ACC_BITS+2-SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS:0] OUT_MIN = ~OUT_MAX;

   logic [SAMPLE_BITS-1:0] hist_mem_ff [TAPS_MAX];
   logic [SAMPLE_BITS-1:0] coef_mem_ff [TAPS_MAX];
   logic [TAPS_MAX-1:0]    hist_vld_ff, hist_vld_in;
   logic [IDX_BITS-1:0]    ptr_ff, ptr_in, ptr_inc;
   logic [IDX_BITS-1:0]    hist_addr;
   logic [IDX_BITS:0]      hist_addr_wide;
   logic [IDX_BITS-1:0]    coef_wr_addr;
   logic                   coef_wr_ok;

   logic [SAMPLE_BITS-1:0]          hist_rd_ff, coef_rd_ff;
   logic                            hist_rd_vld_ff;
   logic                            rd_valid_ff, prod_valid_ff;
   logic signed [SAMPLE_BITS-1:0]   mul_a, mul_b;
   logic signed [2*SAMPLE_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]      acc_ff, acc_in;
   logic signed [ACC_BITS:0]        sum_rnd, shifted;

   // circular history, ptr points at the newest sample
   assign ptr_inc = (ptr_ff == IDX_BITS'(TAPS_MAX-1)) ? '0 : ptr_ff + IDX_BITS'(1);
   assign ptr_in  = cmd.sample_wr ? ptr_inc : ptr_ff;

   always_comb begin
      if (ptr_ff >= cmd.tap_idx) begin
         hist_addr_wide = {1'b0, ptr_ff} - {1'b0, cmd.tap_idx};
      end else begin
         hist_addr_wide = {1'b0, ptr_ff} + (IDX_BITS+1)'(TAPS_MAX) - {1'b0, cmd.tap_idx};
      end
   end
   assign hist_addr = hist_addr_wide[IDX_BITS-1:0];

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (cmd.flush) begin
         hist_vld_in = '0;
      end else if (cmd.sample_wr) begin
         hist_vld_in[ptr_inc] = 1'b1;
      end
   end

   assign coef_wr_ok   = 32'(req_coeff_index) < TAPS_MAX;
   assign coef_wr_addr = IDX_BITS'(req_coeff_index);

   always_ff @(posedge clock) begin
      if (cmd.sample_wr) begin
         hist_mem_ff[ptr_inc] <= req_sample;
      end
      if (cmd.coeff_wr && coef_wr_ok) begin
         coef_mem_ff[coef_wr_addr] <= req_coeff_value;
      end
      hist_rd_ff     <= hist_mem_ff[hist_addr];
      coef_rd_ff     <= coef_mem_ff[cmd.tap_idx];
      hist_rd_vld_ff <= hist_vld_ff[hist_addr];
   end

   // never-written or flushed history entries read as zero
   assign mul_a   = hist_rd_vld_ff ? signed'(hist_rd_ff) : '0;
   assign mul_b   = signed'(coef_rd_ff);
   assign prod_in = mul_a * mul_b;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.sample_wr) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff   <= '0;
         ptr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         hist_vld_ff   <= hist_vld_in;
         ptr_ff        <= ptr_in;
         rd_valid_ff   <= cmd.issue;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   // round half up, floor shift, clip to sample range
   assign sum_rnd = (ACC_BITS+1)'(acc_ff) + RND_HALF;
   assign shifted = sum_rnd >>> (SAMPLE_BITS-1);

   always_comb begin
      if (shifted > OUT_MAX) begin
         filtered  = OUT_MAX[SAMPLE_BITS-1:0];
         saturated = 1'b1;
      end else if (shifted < OUT_MIN) begin
         filtered  = OUT_MIN[SAMPLE_BITS-1:0];
         saturated = 1'b1;
      end else begin
         filtered  = shifted[SAMPLE_BITS-1:0];
         saturated = 1'b0;
      end
   end

endmodule

@@ design/fir_filter_stream.sv @@
// fir_filter_stream: top level of the streaming direct-form fir filter
// depends on fir_pkg, fir_ctrl and fir_datapath
//
//   channel   direction  handshake               content
//   req_*     in         tvalid/tready           sample, coefficient write or flush request
//   rsp_*     out        tvalid/tready           filtered sample and clip flag
//   csr_*     in/out     apb psel/penable        tap_count register at byte address 0
//
// a filter request, with taps the tap_count clipped to 1..64, is accepted, then
// sends each of its taps in turn through the single multiply-accumulate unit,
// empties the read and multiply stages, then rounds and loads the result register
// coefficient write, flush and unused requests complete as they are accepted
// synchronous reset clears the history valid bits and sets tap_count to 64
// the result register parts the sides: a waiting result stalls only the
// next filter request at its final step, never acceptance
module fir_filter_stream
   import fir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sample[15:0], coeff_index[21:16], coeff_value[37:22]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // filtered[15:0]
   output logic [0:0]  rsp_tuser,   // saturated[0]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fir_cmd_type               cmd;
   logic [TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]    rsp_data_ff;
   logic                      rsp_sat_ff;
   logic [SAMPLE_BITS-1:0]    dp_filtered;
   logic                      dp_saturated;
   logic                      rsp_free;
   logic                      csr_wr;

   // configuration register, word index in paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tap_count_in = tap_count_ff;
      if (csr_wr && (csr_paddr[2] == REG_TAP_COUNT)) begin
         tap_count_in = csr_pwdata[TAP_COUNT_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TAP_COUNT) ?
                       {{(32-TAP_COUNT_BITS){1'b0}}, tap_count_ff} : '0;

   // result register is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   fir_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_operation (req_tuser),
      .tap_count     (tap_count_ff),
      .rsp_free      (rsp_free),
      .req_ready     (req_tready),
      .cmd           (cmd)
   );

   fir_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_sample      (req_tdata[15:0]),
      .req_coeff_index (req_tdata[21:16]),
      .req_coeff_value (req_tdata[37:22]),
      .filtered        (dp_filtered),
      .saturated       (dp_saturated)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result payload, loaded at the final step of a filter request
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_data_ff <= dp_filtered;
         rsp_sat_ff  <= dp_saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= TAP_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tap_count_ff <= tap_count_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule
